// ----- design/mstt_pkg.sv -----
// ----------------------------------------------------------------------------
// mstt_pkg: shared definitions for the timeout table
// Holds the slot count, field widths, opcodes, status codes and the structs
// that pass between the cells and the controller.
// ----------------------------------------------------------------------------
package mstt_pkg;

  localparam int SLOTS  = 10;
  localparam int SLOT_W = 4;
  localparam int DUR_W  = 32;
  localparam int OP_W   = 2;
  localparam int ST_W   = 2;

  localparam logic [OP_W-1:0] OP_REG   = 2'd0;
  localparam logic [OP_W-1:0] OP_UNREG = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  // item held by the controller and broadcast to every cell
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] slot_id;
    logic [DUR_W-1:0]  duration;
  } cmd_t;

  // token that walks the chain, one cell per cycle while the output is not stalled
  typedef struct packed {
    logic              vld;
    logic              claimed;
    logic [SLOT_W-1:0] claim_slot;
    logic              pend;
    logic [SLOT_W-1:0] pend_slot;
  } tok_t;

  // an earlier expiry released by a cell that found a later one
  typedef struct packed {
    logic              vld;
    logic [SLOT_W-1:0] slot;
  } emit_t;

endpackage

// ----- design/mstt_if.sv -----
// ----------------------------------------------------------------------------
// mstt_if: item channels of the timeout table
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface mstt_in_if;
  import mstt_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [SLOT_W-1:0] slot_id;
  logic [DUR_W-1:0]  duration;

  modport source (output valid, op, slot_id, duration, input ready);
  modport sink   (input valid, op, slot_id, duration, output ready);
endinterface

interface mstt_out_if;
  import mstt_pkg::*;

  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [SLOT_W-1:0] slot;
  logic              expired;
  logic              last;

  modport source (output valid, status, slot, expired, last, input ready);
  modport sink   (input valid, status, slot, expired, last, output ready);
endinterface

// ----- design/mstt_cell.sv -----
// ----------------------------------------------------------------------------
// mstt_cell: one timeout slot
// Holds the armed flag and remaining count of one slot, acts on the item
// when the token passes and hands the token to the next cell.
// ----------------------------------------------------------------------------
module mstt_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic [mstt_pkg::SLOT_W-1:0] idx,
  input  mstt_pkg::cmd_t           cmd,
  input  mstt_pkg::tok_t           tok_i,
  output mstt_pkg::tok_t           tok_o,
  output mstt_pkg::emit_t          emit_o
);
  import mstt_pkg::*;

  logic [DUR_W-1:0] rem_r, rem_nxt;
  logic             armed_r, armed_nxt;
  tok_t             tok_r, tok_nxt;

  always_comb begin
    rem_nxt   = rem_r;
    armed_nxt = armed_r;
    tok_nxt   = tok_i;
    emit_o    = '0;
    if (tok_i.vld) begin
      case (cmd.op)
        OP_REG: begin
          // first free slot along the chain takes the claim
          if (!armed_r && rem_r == '0 && !tok_i.claimed) begin
            rem_nxt            = cmd.duration;
            armed_nxt          = 1'b1;
            tok_nxt.claimed    = 1'b1;
            tok_nxt.claim_slot = idx;
          end
        end
        OP_UNREG: begin
          if (cmd.slot_id == idx) begin
            rem_nxt   = '0;
            armed_nxt = 1'b0;
          end
        end
        OP_TICK: begin
          if (rem_r != '0) begin
            rem_nxt = rem_r - 1'b1;
            if (rem_r == DUR_W'(1) && armed_r) begin
              armed_nxt = 1'b0;
              // a held expiry is not the last one, release it now
              emit_o.vld        = tok_i.pend;
              emit_o.slot       = tok_i.pend_slot;
              tok_nxt.pend      = 1'b1;
              tok_nxt.pend_slot = idx;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r   <= '0;
      armed_r <= 1'b0;
      tok_r   <= '0;
    end else if (adv) begin
      rem_r   <= rem_nxt;
      armed_r <= armed_nxt;
      tok_r   <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

// ----- design/multi_slot_timeout_table_core.sv -----
// ----------------------------------------------------------------------------
// multi_slot_timeout_table_core: table of one-shot timeout slots
// Register, unregister and tick items sweep a chain of slot cells; results
// leave through a registered output stage.
//
//   channel  | dir | handshake       | payload
//   in_ch    | in  | valid / ready   | op, slot_id, duration
//   out_ch   | out | valid / ready   | status, slot, expired, last
//
// With no output stall a token walks the chain one cell per cycle, then the
// final result is loaded.
// A tick emits its expiries in slot order, each held until a later one is found.
// Reset (rst_n low, synchronous) clears every slot and the output valid flag.
// A stalled output freezes the whole chain; in_ch.ready is low while busy.
// ----------------------------------------------------------------------------
module multi_slot_timeout_table_core (
  input  logic             clk,
  input  logic             rst_n,
  mstt_in_if.sink          in_ch,
  mstt_out_if.source       out_ch
);
  import mstt_pkg::*;

  logic              busy_r;
  cmd_t              cmd_r;
  tok_t              tok0_r;
  logic              out_vld_r;
  logic [ST_W-1:0]   out_status_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_expired_r;
  logic              out_last_r;

  tok_t              tok [SLOTS+1];
  emit_t             emit [SLOTS];
  logic [SLOTS:0]    tok_vld_vec;

  logic              adv;
  logic              accept;
  logic              launch;
  logic              emit_any;
  logic [SLOT_W-1:0] emit_slot;
  tok_t              tok_end;
  logic              fin;
  logic [ST_W-1:0]   fin_status;
  logic [SLOT_W-1:0] fin_slot;
  logic              fin_expired;

  assign adv    = !out_vld_r || out_ch.ready;
  assign accept = in_ch.valid && in_ch.ready;
  assign launch = accept && (in_ch.op == OP_REG || in_ch.op == OP_UNREG ||
                             in_ch.op == OP_TICK);

  // no item is taken while reset is held
  assign in_ch.ready = rst_n && !busy_r;

  assign tok[0] = tok0_r;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    mstt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .idx    (SLOT_W'(i)),
      .cmd    (cmd_r),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1]),
      .emit_o (emit[i])
    );
  end

  // only the cell holding the token can emit, so an or over the row is enough
  always_comb begin
    emit_any  = 1'b0;
    emit_slot = '0;
    for (int i = 0; i < SLOTS; i++) begin
      emit_any  = emit_any | emit[i].vld;
      emit_slot = emit_slot | (emit[i].slot & {SLOT_W{emit[i].vld}});
    end
  end

  always_comb begin
    for (int i = 0; i <= SLOTS; i++) begin
      tok_vld_vec[i] = tok[i].vld;
    end
  end

  assign tok_end = tok[SLOTS];
  assign fin     = tok_end.vld;

  always_comb begin
    fin_status  = ST_OK;
    fin_slot    = '0;
    fin_expired = 1'b0;
    case (cmd_r.op)
      OP_REG: begin
        fin_status = tok_end.claimed ? ST_OK : ST_FULL;
        fin_slot   = tok_end.claimed ? tok_end.claim_slot : '0;
      end
      OP_UNREG: begin
        fin_status = ({1'b0, cmd_r.slot_id} < (SLOT_W+1)'(SLOTS)) ? ST_OK : ST_RANGE;
        fin_slot   = cmd_r.slot_id;
      end
      OP_TICK: begin
        // the held expiry becomes the last result, else an empty one
        fin_slot    = tok_end.pend ? tok_end.pend_slot : '0;
        fin_expired = tok_end.pend;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      tok0_r <= '0;
    end else begin
      if (launch) begin
        busy_r <= 1'b1;
      end else if (fin && adv) begin
        busy_r <= 1'b0;
      end
      if (launch) begin
        tok0_r     <= '0;
        tok0_r.vld <= 1'b1;
      end else if (adv) begin
        tok0_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r.op       <= in_ch.op;
      cmd_r.slot_id  <= in_ch.slot_id;
      cmd_r.duration <= in_ch.duration;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv && emit_any) begin
      out_vld_r <= 1'b1;
    end else if (adv && fin) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit_any) begin
      out_status_r  <= ST_OK;
      out_slot_r    <= emit_slot;
      out_expired_r <= 1'b1;
      out_last_r    <= 1'b0;
    end else if (adv && fin) begin
      out_status_r  <= fin_status;
      out_slot_r    <= fin_slot;
      out_expired_r <= fin_expired;
      out_last_r    <= 1'b1;
    end
  end

  assign out_ch.valid   = out_vld_r;
  assign out_ch.status  = out_status_r;
  assign out_ch.slot    = out_slot_r;
  assign out_ch.expired = out_expired_r;
  assign out_ch.last    = out_last_r;

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vld_vec))
    else $error("more than one token in the chain");

  a_idle_no_token: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (tok_vld_vec == '0))
    else $error("token present while idle");

  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    emit_any |-> busy_r)
    else $error("expiry emitted while idle");

  a_fin_done: assert property (@(posedge clk) disable iff (!rst_n)
    (fin && adv) |=> (!busy_r && out_vld_r && out_last_r))
    else $error("sweep end did not close the item");

endmodule
